[design/abmd_pkg.sv]
// ----------------------------------------------------------------------------
// abmd_pkg: shared types and tables for the ASTC 2D block mode decoder
// Holds the queue entry and configuration structs, register indexes, reset
// values, the integer-sequence size table and the divider reciprocals.
// ----------------------------------------------------------------------------
`default_nettype none

package abmd_pkg;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_WCNT = 2'd0;
  localparam logic [1:0] CFG_MIN_BITS = 2'd1;
  localparam logic [1:0] CFG_MAX_BITS = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] MAX_WCNT_RST = 8'd64;
  localparam logic [6:0] MIN_BITS_RST = 7'd24;
  localparam logic [9:0] MAX_BITS_RST = 10'd96;

  // Divisor select codes of the sequence size table (divisor 1, 3 or 5).
  localparam logic [1:0] DIV_BY1 = 2'd0;
  localparam logic [1:0] DIV_BY3 = 2'd1;
  localparam logic [1:0] DIV_BY5 = 2'd2;

  // Reciprocals for division by 3 and 5, exact for numerators below 4096.
  localparam int unsigned RECIP_SHIFT = 15;
  localparam logic [13:0] RECIP_DIV3  = 14'd10923;
  localparam logic [13:0] RECIP_DIV5  = 14'd6554;

  // Decoded block mode as it travels through the queue.
  typedef struct packed {
    logic       reserved;
    logic [3:0] grid_w;
    logic [3:0] grid_h;
    logic       dual;
    logic [3:0] level;
    logic [6:0] count;
  } entry_t;

  // Configuration registers.
  typedef struct packed {
    logic [7:0] max_wcnt;
    logic [6:0] min_bits;
    logic [9:0] max_bits;
  } cfg_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end status.
  typedef struct packed {
    logic busy;
  } back_stat_t;

  // Scale of the integer-sequence size for a quantization level.
  function automatic logic [4:0] seq_scale(input logic [3:0] level);
    logic [4:0] s;
    case (level)
      4'd0:    s = 5'd1;
      4'd1:    s = 5'd8;
      4'd2:    s = 5'd2;
      4'd3:    s = 5'd7;
      4'd4:    s = 5'd13;
      4'd5:    s = 5'd3;
      4'd6:    s = 5'd10;
      4'd7:    s = 5'd18;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd13;
      4'd10:   s = 5'd23;
      4'd11:   s = 5'd5;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Divisor select for a quantization level.
  function automatic logic [1:0] seq_div_sel(input logic [3:0] level);
    logic [1:0] d;
    case (level)
      4'd1, 4'd4, 4'd7, 4'd10: d = DIV_BY5;
      4'd3, 4'd6, 4'd9:        d = DIV_BY3;
      default:                 d = DIV_BY1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[design/abmd_front.sv]
// ----------------------------------------------------------------------------
// abmd_front: block mode accept and classify stage
// Accepts mode words, splits them into the layout cases and writes the
// decoded grid, plane, level and weight count into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module abmd_front
  import abmd_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] in_mode_word,
  input  wire q_stat_t     q_stat,
  output logic             q_push,
  output entry_t           q_wdata
);

  logic [10:0] m;
  logic [1:0]  a;
  logic [1:0]  b;
  logic [2:0]  r;
  logic        h;
  logic        d;
  logic        reserved;
  logic [3:0]  w;
  logic [3:0]  ht;
  logic [3:0]  level;
  logic [7:0]  wh;
  logic [7:0]  count8;

  assign m = in_mode_word;
  assign a = m[6:5];

  // Accept whenever the queue has room.
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // Layout case decode.
  always_comb begin
    h        = m[9];
    d        = m[10];
    reserved = 1'b0;
    w        = 4'd0;
    ht       = 4'd0;
    b        = m[8:7];
    if (m[1:0] != 2'b00) begin
      r = {m[1:0], m[4]};
      case (m[3:2])
        2'd0: begin
          w  = {2'b00, b} + 4'd4;
          ht = {2'b00, a} + 4'd2;
        end
        2'd1: begin
          w  = {2'b00, b} + 4'd8;
          ht = {2'b00, a} + 4'd2;
        end
        2'd2: begin
          w  = {2'b00, a} + 4'd2;
          ht = {2'b00, b} + 4'd8;
        end
        default: begin
          if (m[8]) begin
            w  = {3'b000, b[0]} + 4'd2;
            ht = {2'b00, a} + 4'd2;
          end else begin
            w  = {2'b00, a} + 4'd2;
            ht = {3'b000, b[0]} + 4'd6;
          end
        end
      endcase
    end else begin
      r = {m[3:2], m[4]};
      b = m[10:9];
      if (m[3:2] == 2'b00) begin
        reserved = 1'b1;
      end else begin
        case (m[8:7])
          2'd0: begin
            w  = 4'd12;
            ht = {2'b00, a} + 4'd2;
          end
          2'd1: begin
            w  = {2'b00, a} + 4'd2;
            ht = 4'd12;
          end
          2'd2: begin
            // Wide grid layout has no dual plane and no high precision.
            w  = {2'b00, a} + 4'd6;
            ht = {2'b00, b} + 4'd6;
            d  = 1'b0;
            h  = 1'b0;
          end
          default: begin
            if (a == 2'd0) begin
              w  = 4'd6;
              ht = 4'd10;
            end else if (a == 2'd1) begin
              w  = 4'd10;
              ht = 4'd6;
            end else begin
              reserved = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Quantization level and weight count.
  assign level  = {1'b0, r} - 4'd2 + (h ? 4'd6 : 4'd0);
  assign wh     = {4'd0, w} * {4'd0, ht};
  assign count8 = d ? {wh[6:0], 1'b0} : wh;

  // Reserved encodings carry all-zero fields.
  always_comb begin
    if (reserved) begin
      q_wdata          = '0;
      q_wdata.reserved = 1'b1;
    end else begin
      q_wdata.reserved = 1'b0;
      q_wdata.grid_w   = w;
      q_wdata.grid_h   = ht;
      q_wdata.dual     = d;
      q_wdata.level    = level;
      q_wdata.count    = count8[6:0];
    end
  end

endmodule

`default_nettype wire

[design/abmd_queue.sv]
// ----------------------------------------------------------------------------
// abmd_queue: decoupling queue between front and back
// A small register queue of decoded entries with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module abmd_queue
  import abmd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wdata,
  input  wire logic   pop,
  output entry_t      rdata,
  output q_stat_t     stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;

  assign stat.full  = (fill_r == CW'(DEPTH));
  assign stat.empty = (fill_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  // Pointer and fill count update; pointers wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[design/abmd_back.sv]
// ----------------------------------------------------------------------------
// abmd_back: weight bit count and limit check pipeline
// Three stages: sequence scale product, division by the table divisor
// through a reciprocal product, then the limit compare into the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module abmd_back
  import abmd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_stat_t q_stat,
  input  wire entry_t  q_rdata,
  output logic         q_pop,
  input  wire cfg_t    cfg,
  output back_stat_t   stat,
  output logic         out_valid,
  input  wire logic    out_stall,
  output logic         out_mode_valid,
  output logic [3:0]   out_grid_width,
  output logic [3:0]   out_grid_height,
  output logic         out_dual_plane,
  output logic [3:0]   out_weight_quant,
  output logic [7:0]   out_weight_total,
  output logic [9:0]   out_weight_bit_total
);

  logic        s1_v_r;
  logic        s1_v_nxt;
  entry_t      s1_ent_r;
  logic [11:0] s1_num_r;
  logic [11:0] s1_num_nxt;
  logic [1:0]  s1_sel_r;
  logic [1:0]  s1_sel_nxt;

  logic        s2_v_r;
  logic        s2_v_nxt;
  entry_t      s2_ent_r;
  logic [9:0]  s2_bits_r;
  logic [9:0]  s2_bits_nxt;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_ok_r;
  logic        out_ok_nxt;
  entry_t      out_ent_r;
  logic [9:0]  out_bits_r;

  logic        ld1;
  logic        ld2;
  logic        ld3;
  logic [13:0] recip;
  logic [25:0] quot_prod;

  // Stage load enables: a stage loads when empty or when it moves on.
  assign ld3   = !out_valid_r || !out_stall;
  assign ld2   = !s2_v_r || ld3;
  assign ld1   = !s1_v_r || ld2;
  assign q_pop = !q_stat.empty && ld1;

  assign stat.busy = s1_v_r || s2_v_r || out_valid_r;

  // Stage 1: scale times count, plus divisor minus one for the ceiling.
  always_comb begin
    s1_sel_nxt = seq_div_sel(q_rdata.level);
    s1_num_nxt = {7'd0, seq_scale(q_rdata.level)} * {5'd0, q_rdata.count}
                 + {9'd0, s1_sel_nxt, 1'b0};
  end

  // Stage 2: divide by 1, 3 or 5.
  always_comb begin
    recip       = (s1_sel_r == DIV_BY3) ? RECIP_DIV3 : RECIP_DIV5;
    quot_prod   = {14'd0, s1_num_r} * {12'd0, recip};
    s2_bits_nxt = (s1_sel_r == DIV_BY1) ? s1_num_r[9:0]
                                        : quot_prod[RECIP_SHIFT +: 10];
  end

  // Stage 3: limit check; reserved encodings are never valid.
  always_comb begin
    out_ok_nxt = !s2_ent_r.reserved
                 && ({1'b0, s2_ent_r.count} <= cfg.max_wcnt)
                 && (s2_bits_r >= {3'd0, cfg.min_bits})
                 && (s2_bits_r <= cfg.max_bits);
  end

  // Valid flags of the stages.
  always_comb begin
    s1_v_nxt      = ld1 ? q_pop : s1_v_r;
    s2_v_nxt      = ld2 ? s1_v_r : s2_v_r;
    out_valid_nxt = ld3 ? s2_v_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_ent_r <= q_rdata;
      s1_num_r <= s1_num_nxt;
      s1_sel_r <= s1_sel_nxt;
    end
    if (ld2) begin
      s2_ent_r  <= s1_ent_r;
      s2_bits_r <= s2_bits_nxt;
    end
    if (ld3) begin
      out_ent_r  <= s2_ent_r;
      out_bits_r <= s2_bits_r;
      out_ok_r   <= out_ok_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mode_valid       = out_ok_r;
  assign out_grid_width       = out_ent_r.grid_w;
  assign out_grid_height      = out_ent_r.grid_h;
  assign out_dual_plane       = out_ent_r.dual;
  assign out_weight_quant     = out_ent_r.level;
  assign out_weight_total     = {1'b0, out_ent_r.count};
  assign out_weight_bit_total = out_bits_r;

endmodule

`default_nettype wire

[design/astc_block_mode_decode_core.sv]
// Path: an accepted mode word is written into the queue, then moves through
//   the scale, divide and check stages into the output register.
// Throughput: one mode word per cycle, three-stage back pipeline, held by out_stall.
// Reset: synchronous, active low; empties queue and pipeline and loads the
//   limit registers with 64 weights, 24 and 96 weight bits.
// ----------------------------------------------------------------------------
// astc_block_mode_decode_core: ASTC 2D block mode decoder
// Front decode into a small queue, back pipeline computes the weight bit
// count and checks it and the weight count against the limit registers.
// ----------------------------------------------------------------------------
`default_nettype none

module astc_block_mode_decode_core
  import abmd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] in_mode_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_mode_valid,
  output logic [3:0]       out_grid_width,
  output logic [3:0]       out_grid_height,
  output logic             out_dual_plane,
  output logic [3:0]       out_weight_quant,
  output logic [7:0]       out_weight_total,
  output logic [9:0]       out_weight_bit_total
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  q_stat_t    q_stat;
  entry_t     q_wdata;
  entry_t     q_rdata;
  logic       q_push;
  logic       q_pop;
  back_stat_t back_stat;

  // Limit register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_WCNT: cfg_nxt.max_wcnt = cfg_wdata[7:0];
        CFG_MIN_BITS: cfg_nxt.min_bits = cfg_wdata[6:0];
        CFG_MAX_BITS: cfg_nxt.max_bits = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_wcnt <= MAX_WCNT_RST;
      cfg_r.min_bits <= MIN_BITS_RST;
      cfg_r.max_bits <= MAX_BITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  abmd_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode_word (in_mode_word),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  abmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  abmd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .q_rdata              (q_rdata),
    .q_pop                (q_pop),
    .cfg                  (cfg_r),
    .stat                 (back_stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mode_valid       (out_mode_valid),
    .out_grid_width       (out_grid_width),
    .out_grid_height      (out_grid_height),
    .out_dual_plane       (out_dual_plane),
    .out_weight_quant     (out_weight_quant),
    .out_weight_total     (out_weight_total),
    .out_weight_bit_total (out_weight_bit_total)
  );

`ifndef ASSERT_OFF
  // The back never takes an entry from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // A zero grid width marks a reserved encoding, which is never valid.
  a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_grid_width == 4'd0) |->
      (!out_mode_valid && out_weight_total == 8'd0 && out_weight_bit_total == 10'd0))
    else $error("reserved encoding reported with nonzero fields");

  // An item entering an idle block reaches the output register on time.
  a_idle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_stat.empty && !back_stat.busy) |-> ##4 out_valid)
    else $error("result missing after idle-block latency");
`endif

endmodule

`default_nettype wire

[test/astc_block_mode_decode_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// astc_block_mode_decode_core_tb: self-checking bench for the block mode decoder
// Feeds 11-bit block mode words through the valid/stall input channel, with a
// behavioral decoder computing the expected grid size, plane count,
// quantization level, weight count, weight bit count and validity flag. The
// limit registers are reprogrammed between phases, and both channels idle in
// random bursts except in the final phase.
// ----------------------------------------------------------------------------

module astc_block_mode_decode_core_tb;
  import abmd_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 1000;
  localparam int unsigned WORDS_PER_PHASE = 175;
  localparam int unsigned LIMIT_PHASES    = 8;

  // One decoded block mode as it leaves the block.
  typedef struct packed {
    logic       mode_valid;
    logic [3:0] grid_width;
    logic [3:0] grid_height;
    logic       dual_plane;
    logic [3:0] weight_quant;
    logic [7:0] weight_total;
    logic [9:0] weight_bit_total;
  } mode_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_WCNT;
  logic [9:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] in_mode_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_mode_valid;
  logic [3:0]  out_grid_width;
  logic [3:0]  out_grid_height;
  logic        out_dual_plane;
  logic [3:0]  out_weight_quant;
  logic [7:0]  out_weight_total;
  logic [9:0]  out_weight_bit_total;

  // Mode words waiting to be sent, and decodes waiting to come back.
  logic [10:0]  mode_words_q[$];
  mode_result_t awaited_modes[$];

  // Shadow copies of the limit registers.
  int unsigned lim_max_wcnt = MAX_WCNT_RST;
  int unsigned lim_min_bits = MIN_BITS_RST;
  int unsigned lim_max_bits = MAX_BITS_RST;

  logic idle_en = 1'b1;
  int   in_gap_left = 0;
  int   out_stall_left = 0;
  int   quiet_cycles = 0;
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_valid = 0;
  int   n_reserved = 0;

  astc_block_mode_decode_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode_word         (in_mode_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mode_valid       (out_mode_valid),
    .out_grid_width       (out_grid_width),
    .out_grid_height      (out_grid_height),
    .out_dual_plane       (out_dual_plane),
    .out_weight_quant     (out_weight_quant),
    .out_weight_total     (out_weight_total),
    .out_weight_bit_total (out_weight_bit_total)
  );

  always #5 clk = ~clk;

  // Decode one mode word against the current limits.
  function automatic mode_result_t decode_mode_word(logic [10:0] m);
    mode_result_t res;
    logic [2:0]   rng;
    logic [1:0]   a;
    logic [1:0]   b;
    logic         hp;
    logic         dp;
    logic         rsv;
    int unsigned  w;
    int unsigned  ht;
    int unsigned  cnt;
    int unsigned  lvl;
    int unsigned  scale;
    int unsigned  dv;
    int unsigned  bits;
    res = '0;
    rsv = 1'b0;
    w = 0;
    ht = 0;
    hp = m[9];
    dp = m[10];
    a = m[6:5];
    rng = 3'b000;
    if (m[1:0] != 2'b00) begin
      // Layouts with a nonzero range field in the two low bits.
      rng = {m[1:0], m[4]};
      b = m[8:7];
      case (m[3:2])
        2'd0: begin w = b + 4; ht = a + 2; end
        2'd1: begin w = b + 8; ht = a + 2; end
        2'd2: begin w = a + 2; ht = b + 8; end
        default: begin
          if (m[8]) begin
            w = m[7] + 2;
            ht = a + 2;
          end else begin
            w = a + 2;
            ht = m[7] + 6;
          end
        end
      endcase
    end else if (m[3:2] == 2'b00) begin
      rsv = 1'b1;
    end else begin
      // Layouts with the low bits zero and the range field in bits 2..3.
      rng = {m[3:2], m[4]};
      b = m[10:9];
      case (m[8:7])
        2'd0: begin w = 12; ht = a + 2; end
        2'd1: begin w = a + 2; ht = 12; end
        2'd2: begin
          // The wide grid has no room for the plane and precision bits.
          w = a + 6;
          ht = b + 6;
          dp = 1'b0;
          hp = 1'b0;
        end
        default: begin
          if (a == 2'd0) begin
            w = 6;
            ht = 10;
          end else if (a == 2'd1) begin
            w = 10;
            ht = 6;
          end else begin
            rsv = 1'b1;
          end
        end
      endcase
    end
    if (!rsv) begin
      cnt = w * ht * (int'(dp) + 1);
      lvl = int'(rng) + 6 * int'(hp) - 2;
      // Integer sequence size: trits pack five values, quints three.
      case (lvl)
        0:  begin scale = 1;  dv = 1; end
        1:  begin scale = 8;  dv = 5; end
        2:  begin scale = 2;  dv = 1; end
        3:  begin scale = 7;  dv = 3; end
        4:  begin scale = 13; dv = 5; end
        5:  begin scale = 3;  dv = 1; end
        6:  begin scale = 10; dv = 3; end
        7:  begin scale = 18; dv = 5; end
        8:  begin scale = 4;  dv = 1; end
        9:  begin scale = 13; dv = 3; end
        10: begin scale = 23; dv = 5; end
        default: begin scale = 5; dv = 1; end
      endcase
      bits = (scale * cnt + dv - 1) / dv;
      res.mode_valid = (cnt <= lim_max_wcnt) && (bits >= lim_min_bits) &&
                       (bits <= lim_max_bits);
      res.grid_width = 4'(w);
      res.grid_height = 4'(ht);
      res.dual_plane = dp;
      res.weight_quant = 4'(lvl);
      res.weight_total = 8'(cnt);
      res.weight_bit_total = 10'(bits);
    end
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Write one limit register; only called while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_WCNT: lim_max_wcnt = data[7:0];
      CFG_MIN_BITS: lim_min_bits = data[6:0];
      CFG_MAX_BITS: lim_max_bits = data[9:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [9:0] max_wcnt, logic [9:0] min_bits, logic [9:0] max_bits);
    write_reg(CFG_MAX_WCNT, max_wcnt);
    write_reg(CFG_MIN_BITS, min_bits);
    write_reg(CFG_MAX_BITS, max_bits);
  endtask

  // Wait until every queued word has been sent and every decode has returned.
  task automatic drain();
    while (mode_words_q.size() != 0 || in_valid || awaited_modes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Input driver: a new transfer is offered once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_mode_word <= '0;
      in_gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (mode_words_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        in_gap_left = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_mode_word <= mode_words_q.pop_front();
      end
    end
  end

  // Output stall generator: random stall bursts while idle_en is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_stall_left = 0;
    end else if (out_stall_left > 0) begin
      out_stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    mode_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_modes.push_back(decode_mode_word(in_mode_word));
        n_sent++;
      end
      if (out_valid && !out_stall) begin
        if (awaited_modes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual valid=%0d w=%0d h=%0d",
                   $time, out_mode_valid, out_grid_width, out_grid_height);
          n_errors++;
        end else begin
          want = awaited_modes.pop_front();
          check_field("mode_valid", want.mode_valid, out_mode_valid);
          check_field("grid_width", want.grid_width, out_grid_width);
          check_field("grid_height", want.grid_height, out_grid_height);
          check_field("dual_plane", want.dual_plane, out_dual_plane);
          check_field("weight_quant", want.weight_quant, out_weight_quant);
          check_field("weight_total", want.weight_total, out_weight_total);
          check_field("weight_bit_total", want.weight_bit_total, out_weight_bit_total);
          n_checked++;
          if (want.mode_valid)
            n_valid++;
          if (want.grid_width == 4'd0)
            n_reserved++;
        end
      end
      // Watchdog on cycles with no transfer on either channel.
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus: directed words at the reset limits, then random phases.
  initial begin
    int unsigned phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reserved words, layouts with nonzero low bits at lowest and highest field
    // values, the wide grid with plane and precision bits set, and the 6x10 /
    // 10x6 layout next to its reserved neighbors.
    mode_words_q.push_back(11'h000);
    mode_words_q.push_back(11'h7FF);
    for (int s = 0; s < 4; s++) begin
      mode_words_q.push_back({1'b0, 1'b0, 2'd0, 2'd0, 1'b0, 2'(s), 2'd1});
      mode_words_q.push_back({1'b1, 1'b1, 2'd3, 2'd3, 1'b1, 2'(s), 2'd3});
    end
    mode_words_q.push_back({1'b1, 1'b1, 2'd1, 2'd3, 1'b1, 2'd3, 2'd2});
    mode_words_q.push_back({1'b1, 1'b1, 2'd0, 2'd3, 1'b1, 2'd3, 2'd0});
    mode_words_q.push_back({1'b1, 1'b1, 2'd1, 2'd3, 1'b1, 2'd3, 2'd0});
    mode_words_q.push_back({1'b1, 1'b1, 2'd2, 2'd3, 1'b1, 2'd3, 2'd0});
    mode_words_q.push_back({1'b0, 1'b0, 2'd2, 2'd0, 1'b0, 2'd1, 2'd0});
    for (int a = 0; a < 4; a++)
      mode_words_q.push_back({1'b0, 1'b1, 2'd3, 2'(a), 1'b1, 2'd2, 2'd0});
    mode_words_q.push_back({1'b1, 1'b1, 2'd3, 2'd3, 1'b1, 2'd0, 2'd0});
    drain();

    for (phase = 0; phase < LIMIT_PHASES; phase++) begin
      case (phase)
        0: set_limits(10'd128, 10'd0, 10'd1023);
        1: set_limits(10'd1, 10'd127, 10'd0);
        2: set_limits(10'd255, 10'd127, 10'd1023);
        3: set_limits(10'd64, 10'd24, 10'd96);
        6: set_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)));
        default: set_limits(10'($urandom_range(1, 128)), 10'($urandom_range(0, 127)),
                            10'($urandom_range(0, 1023)));
      endcase
      // The last phase runs both channels at full rate.
      if (phase == LIMIT_PHASES - 1)
        idle_en = 1'b0;
      for (int i = 0; i < WORDS_PER_PHASE; i++)
        mode_words_q.push_back(11'($urandom_range(0, 2047)));
      drain();
    end

    repeat (8) @(negedge clk);
    if (awaited_modes.size() != 0) begin
      $display("%0t: %0d results missing, expected more, actual none",
               $time, awaited_modes.size());
      n_errors++;
    end
    $display("Sent %0d mode words over %0d limit settings; checked %0d decodes",
             n_sent, LIMIT_PHASES + 1, n_checked);
    $display("  of which %0d were within limits and %0d were reserved encodings",
             n_valid, n_reserved);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
